### rtl/core/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and constants of the fixed block pool allocator.
// ----------------------------------------------------------------------------
package fbpa_pkg;

    localparam int POOL_DEPTH = 256;
    localparam int INDEX_WIDTH = $clog2(POOL_DEPTH);
    localparam int COUNT_WIDTH = INDEX_WIDTH + 1;
    localparam int ADDR_WIDTH = 32;
    localparam int SIZE_WIDTH = 16;
    localparam int PROD_WIDTH = INDEX_WIDTH + SIZE_WIDTH;
    localparam int REG_INDEX_WIDTH = 2;
    localparam int STATUS_WIDTH = 2;

    typedef enum logic [REG_INDEX_WIDTH-1:0] {
        REG_BASE_ADDRESS = 2'd0,
        REG_OBJECT_SIZE  = 2'd1,
        REG_OBJECT_COUNT = 2'd2
    } reg_index_t;

    typedef enum logic [STATUS_WIDTH-1:0] {
        STATUS_OK         = 2'd0,
        STATUS_EMPTY      = 2'd1,
        STATUS_MISALIGNED = 2'd2,
        STATUS_BAD_BLOCK  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ALLOC_READ,
        ST_ALLOC_MUL,
        ST_ALLOC_FINISH,
        ST_FREE_DIVIDE,
        ST_FREE_FINISH
    } state_t;

    typedef struct packed {
        logic div_start;
        logic alloc_read;
        logic alloc_mul;
        logic alloc_finish;
        logic free_finish;
    } command_t;

    typedef struct packed {
        logic div_done;
    } dp_status_t;

    localparam logic [ADDR_WIDTH-1:0] RESET_BASE = '0;
    localparam logic [SIZE_WIDTH-1:0] RESET_SIZE = 16'd256;
    localparam logic [COUNT_WIDTH-1:0] RESET_COUNT = COUNT_WIDTH'(POOL_DEPTH);

    function automatic logic [COUNT_WIDTH-1:0] eff_count(input logic [COUNT_WIDTH-1:0] c);
        logic [COUNT_WIDTH-1:0] r;
        r = c;
        if (c == '0) r = COUNT_WIDTH'(1);
        if (c > COUNT_WIDTH'(POOL_DEPTH)) r = COUNT_WIDTH'(POOL_DEPTH);
        return r;
    endfunction

    function automatic logic [SIZE_WIDTH-1:0] eff_size(input logic [SIZE_WIDTH-1:0] s);
        return (s == '0) ? SIZE_WIDTH'(1) : s;
    endfunction

endpackage

### rtl/core/fbpa_divider.sv
// ----------------------------------------------------------------------------
// fbpa_divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module fbpa_divider
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [fbpa_pkg::ADDR_WIDTH-1:0] dividend,
    input  logic [fbpa_pkg::SIZE_WIDTH-1:0] divisor,
    output logic                           done,
    output logic [fbpa_pkg::ADDR_WIDTH-1:0] quotient,
    output logic [fbpa_pkg::SIZE_WIDTH-1:0] remainder
);
    import fbpa_pkg::*;

    localparam int CNT_WIDTH = $clog2(ADDR_WIDTH);

    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [CNT_WIDTH-1:0]  cnt_reg, cnt_next;
    logic [ADDR_WIDTH-1:0] quo_reg, quo_next;
    logic [SIZE_WIDTH-1:0] rem_reg, rem_next;
    logic [SIZE_WIDTH-1:0] dsr_reg, dsr_next;
    logic [SIZE_WIDTH:0]   trial;
    logic [SIZE_WIDTH:0]   diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[ADDR_WIDTH-1]};
        diff = trial - {1'b0, dsr_reg};
        run_next = run_reg;
        done_next = 1'b0;
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        dsr_next = dsr_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
            quo_next = dividend;
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (run_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_next = diff[SIZE_WIDTH-1:0];
                quo_next = {quo_reg[ADDR_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[SIZE_WIDTH-1:0];
                quo_next = {quo_reg[ADDR_WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CNT_WIDTH'(1);
            if (cnt_reg == CNT_WIDTH'(ADDR_WIDTH - 1))
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            run_reg <= run_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done = done_reg;
    assign quotient = quo_reg;
    assign remainder = rem_reg;

`ifndef ASSERT_OFF
    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !run_reg && $past(run_reg))
        else $error("divider done without a finished run");
`endif

endmodule

### rtl/core/fbpa_ctrl.sv
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Request sequencer of the block pool allocator.
// ----------------------------------------------------------------------------
module fbpa_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic                 operation,
    input  fbpa_pkg::dp_status_t dp_status,
    output fbpa_pkg::command_t   command,
    output logic                 busy
);
    import fbpa_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        command = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (operation)
                    begin
                        command.div_start = 1'b1;
                        state_next = ST_FREE_DIVIDE;
                    end
                    else
                        state_next = ST_ALLOC_READ;
                end
            end
            ST_ALLOC_READ:
            begin
                command.alloc_read = 1'b1;
                state_next = ST_ALLOC_MUL;
            end
            ST_ALLOC_MUL:
            begin
                command.alloc_mul = 1'b1;
                state_next = ST_ALLOC_FINISH;
            end
            ST_ALLOC_FINISH:
            begin
                command.alloc_finish = 1'b1;
                state_next = ST_IDLE;
            end
            ST_FREE_DIVIDE:
            begin
                if (dp_status.div_done)
                    state_next = ST_FREE_FINISH;
            end
            ST_FREE_FINISH:
            begin
                command.free_finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

`ifndef ASSERT_OFF
    a_finish_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (command.alloc_finish || command.free_finish) |=> state_reg == ST_IDLE)
        else $error("finish step did not return to idle");
`endif

endmodule

### rtl/core/fbpa_datapath.sv
// ----------------------------------------------------------------------------
// fbpa_datapath
// Registers, free-index queue, in-use map, divider and result registers.
// ----------------------------------------------------------------------------
module fbpa_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                write_enable,
    input  logic [fbpa_pkg::REG_INDEX_WIDTH-1:0] write_index,
    input  logic [fbpa_pkg::ADDR_WIDTH-1:0]      write_data,
    input  logic [fbpa_pkg::ADDR_WIDTH-1:0]      block_address,
    input  fbpa_pkg::command_t                  command,
    output fbpa_pkg::dp_status_t                dp_status,
    output logic                                done,
    output logic [fbpa_pkg::STATUS_WIDTH-1:0]    status,
    output logic [fbpa_pkg::ADDR_WIDTH-1:0]      result_address,
    output logic [fbpa_pkg::INDEX_WIDTH-1:0]     block_index,
    output logic [fbpa_pkg::COUNT_WIDTH-1:0]     free_blocks,
    output logic [fbpa_pkg::COUNT_WIDTH-1:0]     used_blocks
);
    import fbpa_pkg::*;

    logic [ADDR_WIDTH-1:0]  base_reg;
    logic [SIZE_WIDTH-1:0]  size_reg;
    logic [COUNT_WIDTH-1:0] count_reg;
    logic [INDEX_WIDTH-1:0] head_reg, head_next;
    logic [INDEX_WIDTH-1:0] tail_reg, tail_next;
    logic [COUNT_WIDTH-1:0] free_reg, free_next;
    logic [COUNT_WIDTH-1:0] used_reg, used_next;
    logic [POOL_DEPTH-1:0]  in_use_reg, in_use_next;
    logic [POOL_DEPTH-1:0]  written_reg, written_next;
    logic                   init;
    logic [COUNT_WIDTH-1:0] init_count;

    logic [INDEX_WIDTH-1:0] queue_mem [POOL_DEPTH];
    logic [INDEX_WIDTH-1:0] rd_data_reg;
    logic                   fresh_reg;
    logic [INDEX_WIDTH-1:0] idx_reg;
    logic [PROD_WIDTH-1:0]  prod_reg;
    logic                   queue_write;

    logic [SIZE_WIDTH-1:0]  size_eff;
    logic [COUNT_WIDTH-1:0] count_eff;
    logic [ADDR_WIDTH-1:0]  offset;
    logic [ADDR_WIDTH-1:0]  quotient;
    logic [SIZE_WIDTH-1:0]  remainder;
    logic                   div_done;
    logic [INDEX_WIDTH-1:0] free_idx;
    logic                   free_ok;

    logic                   done_reg, done_next;
    logic [STATUS_WIDTH-1:0] status_reg, status_next;
    logic [ADDR_WIDTH-1:0]  addr_reg, addr_next;
    logic [INDEX_WIDTH-1:0] bidx_reg, bidx_next;

    assign size_eff = eff_size(size_reg);
    assign count_eff = eff_count(count_reg);
    assign offset = block_address - base_reg;
    assign init = write_enable && (write_index == REG_OBJECT_COUNT);
    assign init_count = eff_count(write_data[COUNT_WIDTH-1:0]);

    fbpa_divider u_divider
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (command.div_start),
        .dividend  (offset),
        .divisor   (size_eff),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    assign dp_status.div_done = div_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= RESET_BASE;
            size_reg <= RESET_SIZE;
            count_reg <= RESET_COUNT;
        end
        else if (write_enable)
        begin
            case (write_index)
                REG_BASE_ADDRESS: base_reg <= write_data;
                REG_OBJECT_SIZE:  size_reg <= write_data[SIZE_WIDTH-1:0];
                REG_OBJECT_COUNT: count_reg <= write_data[COUNT_WIDTH-1:0];
                default:          ;
            endcase
        end
    end

    assign free_idx = quotient[INDEX_WIDTH-1:0];
    assign free_ok = (remainder == '0)
                     && (quotient < {{(ADDR_WIDTH-COUNT_WIDTH){1'b0}}, count_eff})
                     && in_use_reg[free_idx];
    assign queue_write = command.free_finish && free_ok;

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        free_next = free_reg;
        used_next = used_reg;
        in_use_next = in_use_reg;
        written_next = written_reg;
        done_next = 1'b0;
        status_next = status_reg;
        addr_next = addr_reg;
        bidx_next = bidx_reg;
        if (init)
        begin
            head_next = '0;
            tail_next = init_count[INDEX_WIDTH-1:0];
            free_next = init_count;
            used_next = '0;
            in_use_next = '0;
            written_next = '0;
        end
        else if (command.alloc_finish)
        begin
            done_next = 1'b1;
            addr_next = '0;
            bidx_next = '0;
            if (free_reg == '0)
                status_next = STATUS_EMPTY;
            else
            begin
                status_next = STATUS_OK;
                addr_next = base_reg + ADDR_WIDTH'(prod_reg);
                bidx_next = idx_reg;
                head_next = head_reg + INDEX_WIDTH'(1);
                free_next = free_reg - COUNT_WIDTH'(1);
                used_next = used_reg + COUNT_WIDTH'(1);
                in_use_next[idx_reg] = 1'b1;
            end
        end
        else if (command.free_finish)
        begin
            done_next = 1'b1;
            addr_next = '0;
            bidx_next = '0;
            if (remainder != '0)
                status_next = STATUS_MISALIGNED;
            else if (!free_ok)
                status_next = STATUS_BAD_BLOCK;
            else
            begin
                status_next = STATUS_OK;
                bidx_next = free_idx;
                in_use_next[free_idx] = 1'b0;
                written_next[tail_reg] = 1'b1;
                tail_next = tail_reg + INDEX_WIDTH'(1);
                free_next = free_reg + COUNT_WIDTH'(1);
                if (used_reg != '0)
                    used_next = used_reg - COUNT_WIDTH'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= RESET_COUNT[INDEX_WIDTH-1:0];
            free_reg <= RESET_COUNT;
            used_reg <= '0;
            in_use_reg <= '0;
            written_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            free_reg <= free_next;
            used_reg <= used_next;
            in_use_reg <= in_use_next;
            written_reg <= written_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (queue_write)
            queue_mem[tail_reg] <= free_idx;
        if (command.alloc_read)
        begin
            rd_data_reg <= queue_mem[head_reg];
            fresh_reg <= !written_reg[head_reg];
        end
        if (command.alloc_mul)
        begin
            idx_reg <= fresh_reg ? head_reg : rd_data_reg;
            prod_reg <= PROD_WIDTH'(fresh_reg ? head_reg : rd_data_reg)
                        * PROD_WIDTH'(size_eff);
        end
        status_reg <= status_next;
        addr_reg <= addr_next;
        bidx_reg <= bidx_next;
    end

    assign done = done_reg;
    assign status = status_reg;
    assign result_address = addr_reg;
    assign block_index = bidx_reg;
    assign free_blocks = free_reg;
    assign used_blocks = used_reg;

`ifndef ASSERT_OFF
    a_counts_balance: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg + used_reg == count_eff)
        else $error("free and used counts do not add up to the pool size");

    a_used_matches_map: assert property (@(posedge clk) disable iff (!rst_n)
        COUNT_WIDTH'($countones(in_use_reg)) == used_reg)
        else $error("used count disagrees with the in-use map");

    a_empty_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        (command.alloc_finish && free_reg == '0 && !init) |=> $stable(head_reg))
        else $error("allocate from an empty pool moved the queue head");
`endif

endmodule

### rtl/core/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block pool with a FIFO free list, in-use map and free checks.
// ----------------------------------------------------------------------------
//  channel   handshake            word
//  request   start & !busy        operation, block_address
//  result    done (one cycle)     status, result_address, block_index,
//                                 free_blocks, used_blocks
//  config    write_enable         write_index, write_data
//
// An allocate goes from acceptance to the done strobe through queue read,
// multiply and add. A free waits on the one-bit-per-cycle divider.
// Reset and a write of object_count rebuild the pool.
// The result is shown for one cycle; the receiver cannot stall it.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                operation,
    input  logic [fbpa_pkg::ADDR_WIDTH-1:0]      block_address,
    output logic                                done,
    output logic [fbpa_pkg::STATUS_WIDTH-1:0]    status,
    output logic [fbpa_pkg::ADDR_WIDTH-1:0]      result_address,
    output logic [fbpa_pkg::INDEX_WIDTH-1:0]     block_index,
    output logic [fbpa_pkg::COUNT_WIDTH-1:0]     free_blocks,
    output logic [fbpa_pkg::COUNT_WIDTH-1:0]     used_blocks,
    input  logic                                write_enable,
    input  logic [fbpa_pkg::REG_INDEX_WIDTH-1:0] write_index,
    input  logic [fbpa_pkg::ADDR_WIDTH-1:0]      write_data
);
    import fbpa_pkg::*;

    command_t   command;
    dp_status_t dp_status;

    fbpa_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .dp_status (dp_status),
        .command   (command),
        .busy      (busy)
    );

    fbpa_datapath u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .write_enable   (write_enable),
        .write_index    (write_index),
        .write_data     (write_data),
        .block_address  (block_address),
        .command        (command),
        .dp_status      (dp_status),
        .done           (done),
        .status         (status),
        .result_address (result_address),
        .block_index    (block_index),
        .free_blocks    (free_blocks),
        .used_blocks    (used_blocks)
    );

endmodule

### tb/sv/fbpa_pool_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbpa_pool_checker
// Watches the request, result and register channels of the block pool
// allocator. It keeps its own copy of the pool: the ring of free indices, the
// in-use map and the register values. It works out the reply owed for every
// accepted request and compares each reply strobe, field by field, with the
// oldest reply still owed.
// ----------------------------------------------------------------------------
package fbpa_tb_pkg;

    typedef enum logic {
        OP_ALLOCATE = 1'b0,
        OP_FREE     = 1'b1
    } op_t;

endpackage

module fbpa_pool_checker
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic                                 operation,
    input  logic [fbpa_pkg::ADDR_WIDTH-1:0]      block_address,
    input  logic                                 done,
    input  logic [fbpa_pkg::STATUS_WIDTH-1:0]    status,
    input  logic [fbpa_pkg::ADDR_WIDTH-1:0]      result_address,
    input  logic [fbpa_pkg::INDEX_WIDTH-1:0]     block_index,
    input  logic [fbpa_pkg::COUNT_WIDTH-1:0]     free_blocks,
    input  logic [fbpa_pkg::COUNT_WIDTH-1:0]     used_blocks,
    input  logic                                 write_enable,
    input  logic [fbpa_pkg::REG_INDEX_WIDTH-1:0] write_index,
    input  logic [fbpa_pkg::ADDR_WIDTH-1:0]      write_data,
    output int                                   pending,
    output int                                   failures
);
    import fbpa_pkg::*;
    import fbpa_tb_pkg::*;

    typedef struct packed {
        status_t                status;
        logic [ADDR_WIDTH-1:0]  address;
        logic [INDEX_WIDTH-1:0] index;
        logic [COUNT_WIDTH-1:0] free_n;
        logic [COUNT_WIDTH-1:0] used_n;
    } pool_reply_t;

    logic [ADDR_WIDTH-1:0]  cfg_base;
    logic [SIZE_WIDTH-1:0]  block_bytes;
    logic [COUNT_WIDTH-1:0] pool_blocks;
    logic [INDEX_WIDTH-1:0] free_ring [POOL_DEPTH];
    logic [INDEX_WIDTH-1:0] ring_head;
    logic [INDEX_WIDTH-1:0] ring_tail;
    logic [COUNT_WIDTH-1:0] n_free;
    logic [COUNT_WIDTH-1:0] n_used;
    logic [POOL_DEPTH-1:0]  allocated;
    pool_reply_t            owed_replies [$];
    int                     replies_seen;

    function automatic void rebuild_pool(input logic [COUNT_WIDTH-1:0] requested);
        int i;
        pool_blocks = requested;
        if (requested == '0) pool_blocks = COUNT_WIDTH'(1);
        if (requested > COUNT_WIDTH'(POOL_DEPTH)) pool_blocks = COUNT_WIDTH'(POOL_DEPTH);
        for (i = 0; i < POOL_DEPTH; i++)
            free_ring[i] = (i < pool_blocks) ? INDEX_WIDTH'(i) : '0;
        ring_head = '0;
        ring_tail = INDEX_WIDTH'(pool_blocks);
        n_free = pool_blocks;
        n_used = '0;
        allocated = '0;
    endfunction

    function automatic pool_reply_t serve_request(input op_t op,
                                                  input logic [ADDR_WIDTH-1:0] addr);
        pool_reply_t            r;
        logic [ADDR_WIDTH-1:0]  offset;
        logic [ADDR_WIDTH-1:0]  slot;
        logic [INDEX_WIDTH-1:0] idx;
        r = '0;
        r.status = STATUS_OK;
        if (op == OP_ALLOCATE)
        begin
            if (n_free == '0)
            begin
                r.status = STATUS_EMPTY;
            end
            else
            begin
                idx = free_ring[ring_head];
                ring_head = ring_head + 1'b1;
                n_free = n_free - 1'b1;
                n_used = n_used + 1'b1;
                allocated[idx] = 1'b1;
                r.address = cfg_base + ADDR_WIDTH'(idx) * ADDR_WIDTH'(block_bytes);
                r.index = idx;
            end
        end
        else
        begin
            offset = addr - cfg_base;
            if (offset % ADDR_WIDTH'(block_bytes) != '0)
            begin
                r.status = STATUS_MISALIGNED;
            end
            else
            begin
                slot = offset / ADDR_WIDTH'(block_bytes);
                if (slot >= ADDR_WIDTH'(pool_blocks))
                begin
                    r.status = STATUS_BAD_BLOCK;
                end
                else if (!allocated[slot[INDEX_WIDTH-1:0]])
                begin
                    r.status = STATUS_BAD_BLOCK;
                end
                else
                begin
                    idx = slot[INDEX_WIDTH-1:0];
                    allocated[idx] = 1'b0;
                    free_ring[ring_tail] = idx;
                    ring_tail = ring_tail + 1'b1;
                    n_free = n_free + 1'b1;
                    if (n_used != '0) n_used = n_used - 1'b1;
                    r.index = idx;
                end
            end
        end
        r.free_n = n_free;
        r.used_n = n_used;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pool_reply_t want;
        if (!rst_n)
        begin
            cfg_base = RESET_BASE;
            block_bytes = RESET_SIZE;
            rebuild_pool(RESET_COUNT);
            owed_replies.delete();
            replies_seen = 0;
            failures = 0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                replies_seen++;
                if (owed_replies.size() == 0)
                begin
                    failures++;
                    if (failures <= 10)
                        $display("Reply %0d arrived with no request outstanding", replies_seen);
                end
                else
                begin
                    want = owed_replies.pop_front();
                    if (status !== want.status || result_address !== want.address ||
                        block_index !== want.index || free_blocks !== want.free_n ||
                        used_blocks !== want.used_n)
                    begin
                        failures++;
                        if (failures <= 10)
                            $display({"Reply %0d mismatch (got/want): status %0d/%0d ",
                                      "address %h/%h index %0d/%0d free %0d/%0d used %0d/%0d"},
                                     replies_seen, status, want.status,
                                     result_address, want.address, block_index, want.index,
                                     free_blocks, want.free_n, used_blocks, want.used_n);
                    end
                end
            end
            if (write_enable)
            begin
                case (write_index)
                    REG_BASE_ADDRESS: cfg_base = write_data;
                    REG_OBJECT_SIZE:
                        block_bytes = (write_data[SIZE_WIDTH-1:0] == '0) ?
                                      SIZE_WIDTH'(1) : write_data[SIZE_WIDTH-1:0];
                    REG_OBJECT_COUNT: rebuild_pool(write_data[COUNT_WIDTH-1:0]);
                    default: ;
                endcase
            end
            if (start && !busy)
                owed_replies.push_back(serve_request(op_t'(operation), block_address));
            pending <= owed_replies.size();
        end
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Regression for the fixed block pool allocator. A short directed sequence
// hits empty pools, double frees, misaligned and out-of-range addresses,
// addresses below the base and the register extremes. Random phases then
// run allocate/free traffic over several pool settings, mostly freeing
// blocks that are really allocated, with bursty request timing. The checker
// beside the block compares every result word.
// ----------------------------------------------------------------------------
module testbench;

    import fbpa_pkg::*;
    import fbpa_tb_pkg::*;

    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 91;
    localparam int CYCLE_LIMIT     = 400000;

    logic                       clk;
    logic                       rst_n;
    logic                       start;
    logic                       busy;
    logic                       operation;
    logic [ADDR_WIDTH-1:0]      block_address;
    logic                       done;
    logic [STATUS_WIDTH-1:0]    status;
    logic [ADDR_WIDTH-1:0]      result_address;
    logic [INDEX_WIDTH-1:0]     block_index;
    logic [COUNT_WIDTH-1:0]     free_blocks;
    logic [COUNT_WIDTH-1:0]     used_blocks;
    logic                       write_enable;
    logic [REG_INDEX_WIDTH-1:0] write_index;
    logic [ADDR_WIDTH-1:0]      write_data;
    int                         pending;
    int                         failures;

    logic [ADDR_WIDTH-1:0] pool_base;
    logic [ADDR_WIDTH-1:0] pool_size;
    logic [ADDR_WIDTH-1:0] pool_count;
    int unsigned           live_blocks [$];
    int unsigned           freed_blocks [$];
    op_t                   issued_ops [$];
    int                    outcome_count [4];
    int                    allocs_sent;
    int                    frees_sent;
    int                    writes_done;
    int                    burst_left;
    int                    cycle_count;

    fixed_block_pool_allocator u_top
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .block_address  (block_address),
        .done           (done),
        .status         (status),
        .result_address (result_address),
        .block_index    (block_index),
        .free_blocks    (free_blocks),
        .used_blocks    (used_blocks),
        .write_enable   (write_enable),
        .write_index    (write_index),
        .write_data     (write_data)
    );

    fbpa_pool_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .block_address  (block_address),
        .done           (done),
        .status         (status),
        .result_address (result_address),
        .block_index    (block_index),
        .free_blocks    (free_blocks),
        .used_blocks    (used_blocks),
        .write_enable   (write_enable),
        .write_index    (write_index),
        .write_data     (write_data),
        .pending        (pending),
        .failures       (failures)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("fixed_block_pool_allocator regression: fail");
            $finish;
        end
    end

    // Allocated indices are learned from the result words so that frees can
    // name blocks that really are in use.
    always @(posedge clk)
    begin : track
        op_t op;
        if (rst_n)
        begin
            if (done && issued_ops.size() != 0)
            begin
                op = issued_ops.pop_front();
                outcome_count[status]++;
                if (op == OP_ALLOCATE && status == STATUS_OK)
                    live_blocks.push_back(block_index);
            end
            if (start && !busy)
                issued_ops.push_back(op_t'(operation));
        end
    end

    task automatic send_request(input op_t op, input logic [ADDR_WIDTH-1:0] addr);
        start <= 1'b1;
        operation <= op;
        block_address <= addr;
        do @(posedge clk); while (busy);
        if (op == OP_ALLOCATE) allocs_sent++;
        else frees_sent++;
    endtask

    task automatic drain_requests();
        start <= 1'b0;
        do @(posedge clk); while (pending != 0 || busy);
    endtask

    task automatic write_register(input reg_index_t which, input logic [ADDR_WIDTH-1:0] value);
        logic [ADDR_WIDTH-1:0] word;
        word = $urandom;
        case (which)
            REG_BASE_ADDRESS:
            begin
                word = value;
                pool_base = value;
            end
            REG_OBJECT_SIZE:
            begin
                word[SIZE_WIDTH-1:0] = value[SIZE_WIDTH-1:0];
                pool_size = (value[SIZE_WIDTH-1:0] == '0) ? 1 : value[SIZE_WIDTH-1:0];
            end
            default:
            begin
                word[COUNT_WIDTH-1:0] = value[COUNT_WIDTH-1:0];
                pool_count = value[COUNT_WIDTH-1:0];
                if (pool_count == 0) pool_count = 1;
                if (pool_count > POOL_DEPTH) pool_count = POOL_DEPTH;
                live_blocks.delete();
                freed_blocks.delete();
            end
        endcase
        write_enable <= 1'b1;
        write_index <= which;
        write_data <= word;
        @(posedge clk);
        write_enable <= 1'b0;
        @(posedge clk);
        writes_done++;
    endtask

    task automatic random_request(input int alloc_bias);
        int                    pick;
        int                    pos;
        logic [ADDR_WIDTH-1:0] idx;
        logic [ADDR_WIDTH-1:0] addr;
        bit                    want_alloc;
        want_alloc = ($urandom_range(0, 99) < alloc_bias);
        if (live_blocks.size() == 0 && $urandom_range(0, 3) != 0) want_alloc = 1'b1;
        if (want_alloc)
        begin
            send_request(OP_ALLOCATE, $urandom);
        end
        else
        begin
            pick = $urandom_range(0, 99);
            addr = $urandom;
            if (pick < 65 && live_blocks.size() != 0)
            begin
                pos = $urandom_range(0, live_blocks.size() - 1);
                idx = live_blocks[pos];
                live_blocks.delete(pos);
                freed_blocks.push_back(idx);
                if (freed_blocks.size() > 8) freed_blocks.delete(0);
                addr = pool_base + idx * pool_size;
            end
            else if (pick < 73 && freed_blocks.size() != 0)
            begin
                idx = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
                addr = pool_base + idx * pool_size;
            end
            else if (pick < 81 && pool_size > 1)
            begin
                idx = $urandom_range(0, pool_count - 1);
                addr = pool_base + idx * pool_size + $urandom_range(1, pool_size - 1);
            end
            else if (pick < 88)
            begin
                idx = pool_count + $urandom_range(0, 300);
                addr = pool_base + idx * pool_size;
            end
            else if (pick < 94)
            begin
                addr = pool_base - $urandom_range(1, 64) * pool_size;
            end
            send_request(OP_FREE, addr);
        end
    endtask

    initial
    begin : stimulus
        int p;
        int k;
        int bias;
        int gap;
        rst_n <= 1'b0;
        start <= 1'b0;
        operation <= OP_ALLOCATE;
        block_address <= '0;
        write_enable <= 1'b0;
        write_index <= REG_BASE_ADDRESS;
        write_data <= '0;
        pool_base = RESET_BASE;
        pool_size = RESET_SIZE;
        pool_count = RESET_COUNT;
        burst_left = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(OP_ALLOCATE, 32'h0000_0000);
        send_request(OP_ALLOCATE, 32'hFFFF_FFFF);
        send_request(OP_FREE, 32'h0000_0100);
        send_request(OP_FREE, 32'h0000_0100);
        send_request(OP_FREE, 32'h0000_0101);
        send_request(OP_FREE, 32'h0001_0000);
        send_request(OP_FREE, 32'hFFFF_FFFF);
        send_request(OP_FREE, 32'hFFFF_FF00);
        send_request(OP_FREE, 32'h0000_0000);
        send_request(OP_ALLOCATE, 32'h0000_0000);

        drain_requests();
        write_register(REG_BASE_ADDRESS, 32'hFFFF_FFFF);
        write_register(REG_OBJECT_SIZE, 32'h0000_0000);
        write_register(REG_OBJECT_COUNT, 32'h0000_0000);
        send_request(OP_ALLOCATE, 32'h0000_0000);
        send_request(OP_ALLOCATE, 32'h0000_0000);
        send_request(OP_FREE, 32'h0000_0000);
        send_request(OP_FREE, 32'hFFFF_FFFF);
        send_request(OP_FREE, 32'hFFFF_FFFF);

        drain_requests();
        write_register(REG_OBJECT_SIZE, 32'h0000_FFFF);
        write_register(REG_BASE_ADDRESS, 32'hFFFF_0000);
        write_register(REG_OBJECT_COUNT, 32'h0000_01FF);
        send_request(OP_ALLOCATE, 32'h0000_0000);
        send_request(OP_FREE, 32'hFFFF_0001);
        send_request(OP_FREE, 32'hFFFF_0000 + 32'd255 * 32'h0000_FFFF);
        send_request(OP_FREE, 32'hFFFF_0000 - 32'h0000_FFFF);
        send_request(OP_FREE, 32'hFFFF_0000);

        for (p = 0; p < PHASES; p++)
        begin
            drain_requests();
            bias = 50;
            case (p)
                0:
                begin
                    write_register(REG_BASE_ADDRESS, $urandom);
                    write_register(REG_OBJECT_SIZE, $urandom_range(1, 64));
                    write_register(REG_OBJECT_COUNT, 8);
                    bias = 55;
                end
                1:
                begin
                    write_register(REG_BASE_ADDRESS, 32'hFFFF_FFFF - $urandom_range(0, 4095));
                    write_register(REG_OBJECT_SIZE, 32'h0000_FFFF);
                    write_register(REG_OBJECT_COUNT, 256);
                    bias = 70;
                end
                2:
                begin
                    write_register(REG_BASE_ADDRESS, 32'h0000_0000);
                    write_register(REG_OBJECT_SIZE, 32'h0000_0000);
                    write_register(REG_OBJECT_COUNT, 2);
                end
                3:
                begin
                    write_register(REG_BASE_ADDRESS, $urandom);
                    write_register(REG_OBJECT_SIZE, $urandom_range(1, 4096));
                    bias = 45;
                end
                4:
                begin
                    write_register(REG_BASE_ADDRESS, $urandom);
                    write_register(REG_OBJECT_SIZE, $urandom_range(1, 65535));
                    write_register(REG_OBJECT_COUNT, $urandom_range(1, 256));
                    bias = 60;
                end
                5:
                begin
                    write_register(REG_BASE_ADDRESS, $urandom);
                    write_register(REG_OBJECT_SIZE, 1 << $urandom_range(0, 15));
                    write_register(REG_OBJECT_COUNT, 32'h0000_01FF);
                end
                6:
                begin
                    write_register(REG_BASE_ADDRESS, $urandom);
                    write_register(REG_OBJECT_SIZE, $urandom_range(1, 65535));
                    write_register(REG_OBJECT_COUNT, 1);
                end
                default:
                begin
                    write_register(REG_BASE_ADDRESS, RESET_BASE);
                    write_register(REG_OBJECT_SIZE, RESET_SIZE);
                    write_register(REG_OBJECT_COUNT, RESET_COUNT);
                    bias = 60;
                end
            endcase
            for (k = 0; k < ITEMS_PER_PHASE; k++)
            begin
                if (p % 2 == 1 && k == ITEMS_PER_PHASE / 2)
                begin
                    drain_requests();
                end
                else if (p != 1 && burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 24);
                    gap = $urandom_range(0, 12);
                    if (gap > 0)
                    begin
                        start <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
                if (burst_left > 0) burst_left--;
                random_request(bias);
            end
        end

        drain_requests();
        repeat (40) @(posedge clk);
        $display("Sent %0d requests (%0d allocate, %0d free) with %0d register writes.",
                 allocs_sent + frees_sent, allocs_sent, frees_sent, writes_done);
        $display("Outcomes: %0d ok, %0d pool empty, %0d misaligned, %0d bad block.",
                 outcome_count[STATUS_OK], outcome_count[STATUS_EMPTY],
                 outcome_count[STATUS_MISALIGNED], outcome_count[STATUS_BAD_BLOCK]);
        if (failures == 0)
            $display("fixed_block_pool_allocator regression: pass");
        else
            $display("fixed_block_pool_allocator regression: fail");
        $finish;
    end

endmodule
